// ----- hdl/dic_pkg.sv -----
// Package for the double/int64 converter: action codes and payload structs.
// Used by every module of the converter; depends on nothing.
package dic_pkg;

  typedef enum logic [2:0] {
    ACT_D2S64 = 3'd0,
    ACT_D2U64 = 3'd1,
    ACT_S64TOD = 3'd2,
    ACT_U64TOD = 3'd3,
    ACT_TRUNC = 3'd4,
    ACT_ROUND = 3'd5
  } action_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [63:0] operand;
  } in_req_t;

  typedef struct packed {
    logic [63:0] result;
    logic        invalid;
  } out_req_t;

  localparam logic [63:0] SIGN_BIT  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] ABS_MASK  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] QUIET_BIT = 64'h0008_0000_0000_0000;
  localparam logic [63:0] ONE_DBL   = 64'h3FF0_0000_0000_0000;

endpackage

// ----- hdl/dic_core.sv -----
// Combinational conversion datapath between the input and result registers.
// Depends on dic_pkg.
module dic_core (
  input  dic_pkg::in_req_t  req,
  output dic_pkg::out_req_t rsp
);
  import dic_pkg::*;

  logic        neg;
  logic [10:0] e;
  logic [51:0] frac;
  logic        is_nan, is_inf;
  logic [52:0] sig;
  logic [63:0] mag;
  logic        ovf;
  logic [11:0] up_sh;
  logic [11:0] dn_sh;
  logic [63:0] imag;
  logic [5:0]  p;
  logic        found;
  logic [63:0] norm;
  logic        rbit, sticky, inc;
  logic [53:0] keep;
  logic [10:0] dexp;
  logic [63:0] dbl;
  logic [63:0] fmask;
  logic [63:0] rm;
  logic [63:0] res;
  logic        inv;

  always_comb begin
    neg = req.operand[63];
    e = req.operand[62:52];
    frac = req.operand[51:0];
    is_nan = (e == 11'h7FF) && (frac != '0);
    is_inf = (e == 11'h7FF) && (frac == '0);
    sig = {(e != '0), frac};

    // Truncated magnitude of a finite double.
    ovf = 1'b0;
    mag = '0;
    up_sh = 12'(e) - 12'd1075;
    dn_sh = 12'd1075 - 12'((e != '0) ? e : 11'd1);
    if (e >= 11'd1075) begin
      if (up_sh > 12'd11) ovf = 1'b1;
      else mag = {11'b0, sig} << up_sh[3:0];
    end else if (dn_sh < 12'd64) begin
      mag = {11'b0, sig} >> dn_sh[5:0];
    end
    if (is_inf) begin
      ovf = 1'b1;
      mag = '0;
    end

    // Integer to double, round to nearest even.
    imag = (req.action == ACT_S64TOD && neg) ? (64'd0 - req.operand) : req.operand;
    p = '0;
    found = 1'b0;
    for (int i = 63; i >= 0; i--) begin
      if (!found && imag[i]) begin
        p = 6'(i);
        found = 1'b1;
      end
    end
    norm = imag << (6'd63 - p);
    rbit = norm[10];
    sticky = (norm[9:0] != '0);
    inc = rbit && (sticky || norm[11]);
    keep = {1'b0, norm[63:11]} + 54'(inc);
    dexp = 11'(p) + 11'd1023;
    if (keep[53]) begin
      keep = keep >> 1;
      dexp = dexp + 11'd1;
    end
    dbl = found ? {(req.action == ACT_S64TOD) && neg, dexp, keep[51:0]} : '0;

    fmask = (e >= 11'd1023 && e < 11'd1075) ?
            ((64'd1 << (12'd1075 - 12'(e))) - 64'd1) : '0;
    rm = ((req.operand & ABS_MASK) + ((fmask + 64'd1) >> 1)) & ~fmask;

    res = '0;
    inv = 1'b0;
    case (req.action)
      ACT_D2S64: begin
        if (is_nan) inv = 1'b1;
        else if (!neg) begin
          if (ovf || mag[63]) begin res = ABS_MASK; inv = 1'b1; end
          else res = mag;
        end else begin
          if (ovf || mag > SIGN_BIT) begin res = SIGN_BIT; inv = 1'b1; end
          else res = 64'd0 - mag;
        end
      end
      ACT_D2U64: begin
        if (is_nan) inv = 1'b1;
        else if (!neg) begin
          if (ovf) begin res = '1; inv = 1'b1; end
          else res = mag;
        end
      end
      ACT_S64TOD, ACT_U64TOD: res = dbl;
      ACT_TRUNC, ACT_ROUND: begin
        if (is_nan) begin
          res = req.operand | QUIET_BIT;
          inv = 1'b1;
        end else if (e >= 11'd1075) res = req.operand;
        else if (req.action == ACT_TRUNC) begin
          if (e >= 11'd1023) res = req.operand & ~fmask;
        end else begin
          if (e == 11'd1022) res = (req.operand & SIGN_BIT) | ONE_DBL;
          else if (e > 11'd1022) res = (req.operand & SIGN_BIT) | rm;
        end
      end
      default: inv = 1'b1;
    endcase
    rsp.result = res;
    rsp.invalid = inv;
  end
endmodule

// ----- hdl/double_int64_converter.sv -----
// Top level of the double/int64 converter: input register, datapath, result register.
// Depends on dic_pkg and dic_core.
//
// Converts IEEE doubles to and from 64-bit integers, and truncates or rounds
// doubles to integral values. One request is accepted per cycle while in_ready is
// high; each request passes through the input register, a single pass of
// conversion logic and the result register. The result register is reloaded
// whenever it is empty or being taken, so a stall on the result side holds
// the input side only when both stages are full.
module double_int64_converter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  dic_pkg::in_req_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output dic_pkg::out_req_t  out_data
);
  import dic_pkg::*;

  in_req_t  stg_r;
  logic     stg_v_r, stg_v_nxt;
  out_req_t res_r;
  out_req_t core_rsp;
  logic     out_v_r, out_v_nxt;
  logic     adv;

  dic_core u_core (.req(stg_r), .rsp(core_rsp));

  assign adv = !out_v_r || out_ready;
  assign in_ready = !stg_v_r || adv;
  assign out_valid = out_v_r;
  assign out_data = res_r;

  always_comb begin
    out_v_nxt = adv ? stg_v_r : out_v_r;
    stg_v_nxt = in_ready ? in_valid : stg_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      stg_v_r <= stg_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) stg_r <= in_data;
    if (adv && stg_v_r) res_r <= core_rsp;
  end
endmodule
